/* rtl/bps_patch_apply_unit_defines.svh */
// assertion macros used by the port-level checker
`ifndef BPS_PATCH_APPLY_UNIT_DEFINES_SVH
`define BPS_PATCH_APPLY_UNIT_DEFINES_SVH
// property that must hold at every clock edge out of reset
`define BPS_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
// implication from one cycle to the next
`define BPS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: check failed");
`endif

/* rtl/bpa_pkg.sv */
// shared types and constants for the patch applier
package bpa_pkg;
    // request codes
    localparam logic [1:0] REQ_SRC  = 2'd0;
    localparam logic [1:0] REQ_PAT  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;
    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SMALL  = 3'd1;
    localparam logic [2:0] ST_MAGIC  = 3'd2;
    localparam logic [2:0] ST_PCRC   = 3'd3;
    localparam logic [2:0] ST_RANGE  = 3'd6;
    // actions
    localparam logic [1:0] ACT_SREAD = 2'd0;
    localparam logic [1:0] ACT_TREAD = 2'd1;
    localparam logic [1:0] ACT_SCOPY = 2'd2;
    // register indexes
    localparam logic [1:0] REG_PLEN   = 2'd0;
    localparam logic [1:0] REG_IGNORE = 2'd1;
    localparam logic [1:0] REG_STRICT = 2'd2;
    localparam int unsigned MIN_PATCH = 19;
    localparam int unsigned FOOTER_LEN = 12;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    // parse phases
    typedef enum logic [3:0] {
        PH_MAGIC, PH_SRCSIZE, PH_TGTSIZE, PH_METASIZE, PH_META, PH_CMD,
        PH_TREAD, PH_OFFSET, PH_COPY, PH_FOOTER, PH_DONE, PH_ERROR
    } t_phase;

    // controller commands to the datapath
    typedef struct packed {
        logic src_load;   // store a source byte
        logic pat_start;  // process a patch byte
        logic tick_rd;    // issue copy read
        logic tick_wr;    // complete copy write
        logic nop;        // item with no effect, report state only
    } t_cmd;

    // one-byte crc update, eight dependent narrow steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage

/* rtl/bpa_ram.sv */
// generic RAM with one write port and one registered read port
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/bpa_ctrl.sv */
// controller: sequences each item through its cycles
module bpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_req_type,
    input  logic              i_tick_ok,
    output logic              o_busy,
    output bpa_pkg::t_cmd     o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} t_state;
    t_state r_state;
    logic   r_rd_go;

    // state and registered commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_go <= 1'b0;
        end else begin
            r_rd_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start && i_req_type == bpa_pkg::REQ_TICK && i_tick_ok) begin
                        r_state <= S_READ;
                        r_rd_go <= 1'b1;
                    end
                end
                S_READ:  r_state <= S_WRITE;
                S_WRITE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    always_comb begin
        o_cmd.src_load  = i_start && !o_busy && i_req_type == bpa_pkg::REQ_SRC;
        o_cmd.pat_start = i_start && !o_busy && i_req_type == bpa_pkg::REQ_PAT;
        o_cmd.tick_rd   = i_start && !o_busy && i_req_type == bpa_pkg::REQ_TICK
                          && i_tick_ok;
        o_cmd.tick_wr   = (r_state == S_WRITE) && !r_rd_go;
        // idle ticks and unused request codes still give a beat
        o_cmd.nop       = i_start && !o_busy &&
                          (i_req_type == bpa_pkg::REQ_NONE ||
                           (i_req_type == bpa_pkg::REQ_TICK && !i_tick_ok));
    end
endmodule

/* rtl/bpa_datapath.sv */
// datapath: parser state, stores, crcs and results
module bpa_datapath #(
    parameter int SOURCE_DEPTH = 65536,
    parameter int TARGET_DEPTH = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bpa_pkg::t_cmd i_cmd,
    input  logic [7:0]    i_byte_value,
    input  logic [23:0]   i_patch_length,
    input  logic [2:0]    i_ignore_crc_mask,
    input  logic [2:0]    i_strict_crc_mask,
    output logic          o_tick_ok,
    output logic          o_res_valid,
    output logic          o_out_valid,
    output logic [15:0]   o_out_offset,
    output logic [7:0]    o_out_byte,
    output logic          o_busy_res,
    output logic          o_done_res,
    output logic [2:0]    o_status,
    output logic [2:0]    o_warn_flags,
    output logic          o_size_mismatch
);
    localparam int SAW = $clog2(SOURCE_DEPTH);
    localparam int TAW = $clog2(TARGET_DEPTH);

    bpa_pkg::t_phase r_phase, n_phase;
    logic [24:0] r_src_count, n_src_count;
    logic [23:0] r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic [32:0] r_shift, n_shift;
    logic [31:0] r_dsrc, n_dsrc, r_dtgt, n_dtgt, r_meta, n_meta;
    logic [1:0]  r_act, n_act;
    logic [31:0] r_run, n_run, r_wofs, n_wofs, r_srel, n_srel, r_trel, n_trel;
    logic [31:0] r_crcp, n_crcp, r_crcs, n_crcs, r_crct, n_crct;
    logic [95:0] r_foot, n_foot;
    logic [2:0]  r_status, n_status, r_warn, n_warn;
    logic        r_src_known, n_src_known, r_fin, n_fin;
    logic        r_rv, n_rv, r_ov, n_ov;
    logic [15:0] r_oofs, n_oofs;
    logic [7:0]  r_obyte, n_obyte;
    // copy read in flight: read address and byte source
    logic [31:0] r_rd_addr;
    logic        r_rd_tgt;
    logic [7:0]  r_last_byte;
    logic [31:0] r_last_ofs;
    logic        r_last_v;

    // memories
    logic           src_we, tgt_we;
    logic [SAW-1:0] src_raddr;
    logic [TAW-1:0] tgt_raddr;
    logic [7:0]     src_rdata, tgt_rdata, wr_b;

    bpa_ram #(.WIDTH(8), .DEPTH(SOURCE_DEPTH)) u_src (
        .i_clk(i_clk), .i_we(src_we), .i_waddr(r_src_count[SAW-1:0]),
        .i_wdata(i_byte_value), .i_raddr(src_raddr), .o_rdata(src_rdata));
    bpa_ram #(.WIDTH(8), .DEPTH(TARGET_DEPTH)) u_tgt (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(r_wofs[TAW-1:0]),
        .i_wdata(wr_b), .i_raddr(tgt_raddr), .o_rdata(tgt_rdata));

    logic active;
    assign active = (r_phase != bpa_pkg::PH_ERROR) && (r_phase != bpa_pkg::PH_DONE);

    // copy range check and address select at tick issue
    logic        tick_err;
    logic [31:0] tick_addr;
    always_comb begin
        tick_err  = 1'b0;
        tick_addr = r_wofs;
        case (r_act)
            bpa_pkg::ACT_SREAD: tick_err = ({7'd0, r_src_count} <= r_wofs);
            bpa_pkg::ACT_SCOPY: begin
                tick_err  = ({7'd0, r_src_count} <= r_srel);
                tick_addr = r_srel;
            end
            default: begin
                tick_err  = (r_trel >= r_wofs) || (r_trel >= TARGET_DEPTH);
                tick_addr = r_trel;
            end
        endcase
    end
    assign o_tick_ok = active && (r_phase == bpa_pkg::PH_COPY);
    // memories read the latched copy address during the read cycle
    assign src_raddr = r_rd_addr[SAW-1:0];
    assign tgt_raddr = r_rd_addr[TAW-1:0];

    // copy byte with forwarding of the byte written just before
    logic [7:0] copy_b;
    assign copy_b = !r_rd_tgt ? src_rdata :
                    (r_last_v && r_last_ofs == r_rd_addr) ? r_last_byte : tgt_rdata;

    // varint step on the incoming byte
    logic [63:0] vi_sum, vi_sum2;
    logic [32:0] vi_sh;
    logic [31:0] vi_val;
    always_comb begin
        vi_sum = {32'd0, r_acc} + {25'd0, i_byte_value[6:0]} * {31'd0, r_shift};
        if (vi_sum > 64'hFFFFFFFF) vi_sum = 64'hFFFFFFFF;
        vi_sh = (r_shift[32] || r_shift[31:25] != 7'd0) ? 33'h100000000 : (r_shift << 7);
        vi_sum2 = vi_sum + {31'd0, vi_sh};
        if (vi_sum2 > 64'hFFFFFFFF) vi_sum2 = 64'hFFFFFFFF;
        vi_val = vi_sum[31:0];
    end

    // next-state logic
    always_comb begin
        logic [23:0] fstart;
        logic        wr_en, wr_ok, dofin, do_end_run;
        logic [31:0] wb;
        logic [31:0] stored [3];
        logic [31:0] actual [3];
        n_phase = r_phase; n_src_count = r_src_count; n_pos = r_pos;
        n_acc = r_acc; n_shift = r_shift; n_dsrc = r_dsrc; n_dtgt = r_dtgt;
        n_meta = r_meta; n_act = r_act; n_run = r_run; n_wofs = r_wofs;
        n_srel = r_srel; n_trel = r_trel; n_crcp = r_crcp; n_crcs = r_crcs;
        n_crct = r_crct; n_foot = r_foot; n_status = r_status; n_warn = r_warn;
        n_src_known = r_src_known; n_fin = r_fin;
        n_rv = 1'b0; n_ov = 1'b0; n_oofs = 16'd0; n_obyte = 8'd0;
        src_we = 1'b0; tgt_we = 1'b0; wr_b = 8'd0;
        fstart = i_patch_length - 24'(bpa_pkg::FOOTER_LEN);
        wr_en = 1'b0; wb = 32'd0; dofin = 1'b0; do_end_run = 1'b0; wr_ok = 1'b0;

        if (i_cmd.src_load) begin
            n_rv = 1'b1;
            if (active && r_pos == 24'd0 && r_src_count < SOURCE_DEPTH) begin
                src_we = 1'b1;
                n_src_count = r_src_count + 25'd1;
                n_crcs = bpa_pkg::crc_byte(r_crcs, i_byte_value);
            end
        end else if (i_cmd.tick_rd) begin
            if (active && r_phase == bpa_pkg::PH_COPY && tick_err) begin
                n_status = bpa_pkg::ST_RANGE;
                n_phase = bpa_pkg::PH_ERROR;
            end else if (r_act == bpa_pkg::ACT_SCOPY) begin
                n_srel = r_srel + 32'd1;
            end else if (r_act != bpa_pkg::ACT_SREAD) begin
                n_trel = r_trel + 32'd1;
            end
        end else if (i_cmd.tick_wr) begin
            n_rv = 1'b1;
            if (active) begin
                wr_en = 1'b1; wb = {24'd0, copy_b}; do_end_run = 1'b1;
            end
        end else if (i_cmd.nop) begin
            n_rv = 1'b1;
        end else if (i_cmd.pat_start) begin
            n_rv = 1'b1;
            if (active && r_phase != bpa_pkg::PH_COPY) begin
                if (i_patch_length < 24'(bpa_pkg::MIN_PATCH)) begin
                    n_status = bpa_pkg::ST_SMALL;
                    n_phase = bpa_pkg::PH_ERROR;
                end else begin
                    if (r_pos < i_patch_length - 24'd4)
                        n_crcp = bpa_pkg::crc_byte(r_crcp, i_byte_value);
                    if (r_pos >= fstart && r_pos < i_patch_length)
                        n_foot[(r_pos - fstart)*8 +: 8] = i_byte_value;
                    case (r_phase)
                        bpa_pkg::PH_MAGIC: begin
                            if (r_pos > 24'd3 ||
                                i_byte_value != (r_pos == 24'd0 ? 8'h42 :
                                                 r_pos == 24'd1 ? 8'h50 :
                                                 r_pos == 24'd2 ? 8'h53 : 8'h31)) begin
                                n_status = bpa_pkg::ST_MAGIC;
                                n_phase = bpa_pkg::PH_ERROR;
                            end else if (r_pos == 24'd3) begin
                                n_phase = bpa_pkg::PH_SRCSIZE;
                            end
                        end
                        bpa_pkg::PH_SRCSIZE, bpa_pkg::PH_TGTSIZE, bpa_pkg::PH_METASIZE,
                        bpa_pkg::PH_OFFSET: begin
                            if (i_byte_value[7]) begin
                                n_acc = 32'd0; n_shift = 33'd1;
                                case (r_phase)
                                    bpa_pkg::PH_SRCSIZE: begin
                                        n_dsrc = vi_val; n_src_known = 1'b1;
                                        n_phase = bpa_pkg::PH_TGTSIZE;
                                    end
                                    bpa_pkg::PH_TGTSIZE: begin
                                        n_dtgt = vi_val;
                                        if (vi_val > TARGET_DEPTH) begin
                                            n_status = bpa_pkg::ST_RANGE;
                                            n_phase = bpa_pkg::PH_ERROR;
                                        end else n_phase = bpa_pkg::PH_METASIZE;
                                    end
                                    bpa_pkg::PH_METASIZE: begin
                                        n_meta = vi_val;
                                        n_phase = (vi_val != 0) ? bpa_pkg::PH_META
                                                                : bpa_pkg::PH_CMD;
                                    end
                                    default: begin
                                        if (r_act == bpa_pkg::ACT_SCOPY)
                                            n_srel = vi_val[0] ? r_srel - (vi_val >> 1)
                                                               : r_srel + (vi_val >> 1);
                                        else
                                            n_trel = vi_val[0] ? r_trel - (vi_val >> 1)
                                                               : r_trel + (vi_val >> 1);
                                        n_phase = bpa_pkg::PH_COPY;
                                    end
                                endcase
                            end else begin
                                n_acc = vi_sum2[31:0]; n_shift = vi_sh;
                            end
                        end
                        bpa_pkg::PH_META: begin
                            n_meta = r_meta - 32'd1;
                            if (r_meta == 32'd1) n_phase = bpa_pkg::PH_CMD;
                        end
                        bpa_pkg::PH_CMD: begin
                            if (r_pos >= fstart) n_phase = bpa_pkg::PH_FOOTER;
                            else if (i_byte_value[7]) begin
                                n_acc = 32'd0; n_shift = 33'd1;
                                n_act = vi_val[1:0];
                                n_run = (vi_val >> 2) + 32'd1;
                                n_phase = (vi_val[1:0] == bpa_pkg::ACT_SREAD) ?
                                          bpa_pkg::PH_COPY :
                                          (vi_val[1:0] == bpa_pkg::ACT_TREAD) ?
                                          bpa_pkg::PH_TREAD : bpa_pkg::PH_OFFSET;
                            end else begin
                                n_acc = vi_sum2[31:0]; n_shift = vi_sh;
                            end
                        end
                        bpa_pkg::PH_TREAD: begin
                            wr_en = 1'b1; wb = {24'd0, i_byte_value}; do_end_run = 1'b1;
                        end
                        default: ;
                    endcase
                    n_pos = r_pos + 24'd1;
                end
            end
        end

        // target write shared by target read and copies
        if (wr_en) begin
            if (r_wofs >= r_dtgt || r_wofs >= TARGET_DEPTH) begin
                n_status = bpa_pkg::ST_RANGE;
                n_phase = bpa_pkg::PH_ERROR;
            end else begin
                wr_ok = 1'b1;
                tgt_we = 1'b1; wr_b = wb[7:0];
                n_crct = bpa_pkg::crc_byte(r_crct, wb[7:0]);
                n_ov = 1'b1; n_oofs = r_wofs[15:0]; n_obyte = wb[7:0];
                n_wofs = r_wofs + 32'd1;
                if (do_end_run) begin
                    n_run = r_run - 32'd1;
                    if (r_run == 32'd1) n_phase = bpa_pkg::PH_CMD;
                end
            end
        end

        // end of patch
        if (i_cmd.pat_start && n_phase != bpa_pkg::PH_ERROR && n_phase != bpa_pkg::PH_COPY
            && active && r_phase != bpa_pkg::PH_COPY && n_pos >= i_patch_length
            && i_patch_length >= 24'(bpa_pkg::MIN_PATCH))
            dofin = 1'b1;
        if (i_cmd.tick_wr && wr_ok && n_phase == bpa_pkg::PH_CMD && r_pos >= i_patch_length)
            dofin = 1'b1;
        stored[0] = n_foot[95:64]; stored[1] = n_foot[31:0]; stored[2] = n_foot[63:32];
        actual[0] = ~n_crcp; actual[1] = ~n_crcs; actual[2] = ~n_crct;
        if (dofin) begin
            n_fin = 1'b1;
            n_phase = bpa_pkg::PH_DONE;
            for (int i = 2; i >= 0; i--) begin
                if (!i_ignore_crc_mask[i] && stored[i] != actual[i]) begin
                    if (i_strict_crc_mask[i]) begin
                        n_status = bpa_pkg::ST_PCRC + 3'(i);
                        n_phase = bpa_pkg::PH_ERROR;
                    end
                end
            end
            for (int i = 0; i < 3; i++) begin
                if (!i_ignore_crc_mask[i] && stored[i] != actual[i]
                    && !i_strict_crc_mask[i]) begin
                    // warnings only up to the first strict mismatch
                    logic blocked;
                    blocked = 1'b0;
                    for (int j = 0; j < 3; j++)
                        if (j < i && !i_ignore_crc_mask[j] && stored[j] != actual[j]
                            && i_strict_crc_mask[j]) blocked = 1'b1;
                    if (!blocked) n_warn[i] = 1'b1;
                end
            end
        end
        if (n_phase == bpa_pkg::PH_ERROR) n_ov = 1'b0;
        if (n_phase == bpa_pkg::PH_ERROR) begin n_oofs = 16'd0; n_obyte = 8'd0; end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bpa_pkg::PH_MAGIC; r_src_count <= '0; r_pos <= '0;
            r_acc <= '0; r_shift <= 33'd1; r_dsrc <= '0; r_dtgt <= '0; r_meta <= '0;
            r_act <= '0; r_run <= '0; r_wofs <= '0; r_srel <= '0; r_trel <= '0;
            r_crcp <= '1; r_crcs <= '1; r_crct <= '1; r_foot <= '0;
            r_status <= '0; r_warn <= '0; r_src_known <= 1'b0; r_fin <= 1'b0;
            r_rv <= 1'b0; r_ov <= 1'b0; r_last_v <= 1'b0;
        end else begin
            r_phase <= n_phase; r_src_count <= n_src_count; r_pos <= n_pos;
            r_acc <= n_acc; r_shift <= n_shift; r_dsrc <= n_dsrc; r_dtgt <= n_dtgt;
            r_meta <= n_meta; r_act <= n_act; r_run <= n_run; r_wofs <= n_wofs;
            r_srel <= n_srel; r_trel <= n_trel; r_crcp <= n_crcp; r_crcs <= n_crcs;
            r_crct <= n_crct; r_foot <= n_foot; r_status <= n_status; r_warn <= n_warn;
            r_src_known <= n_src_known; r_fin <= n_fin; r_rv <= n_rv; r_ov <= n_ov;
            if (tgt_we) r_last_v <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_oofs <= n_oofs;
        r_obyte <= n_obyte;
        if (i_cmd.tick_rd) begin
            r_rd_addr <= tick_addr;
            r_rd_tgt  <= (r_act != bpa_pkg::ACT_SREAD) && (r_act != bpa_pkg::ACT_SCOPY);
        end
        if (tgt_we) begin
            r_last_byte <= wr_b;
            r_last_ofs  <= r_wofs;
        end
    end

    assign o_res_valid     = r_rv;
    assign o_out_valid     = r_ov;
    assign o_out_offset    = r_oofs;
    assign o_out_byte      = r_obyte;
    assign o_busy_res      = (r_phase == bpa_pkg::PH_COPY);
    assign o_done_res      = r_fin;
    assign o_status        = r_status;
    assign o_warn_flags    = r_warn;
    assign o_size_mismatch = r_src_known && ({7'd0, r_src_count} != r_dsrc);
endmodule

/* rtl/bps_patch_apply_unit.sv */
// top level of the bps patch applier
// Usage: load configuration over the register port (patch_length at 0x0,
// ignore mask at 0x4, strict mask at 0x8) while idle. Then send items with
// start while busy is low: source bytes first, then patch bytes, then
// ticks while o_busy_res shows pending copy bytes.
// Every accepted item gives exactly one result beat, marked by o_res_valid,
// held for one cycle; the receiver cannot stall it.
// Source bytes, patch bytes, idle ticks and unused request codes
// give their beat in the cycle right after acceptance (one register stage)
// and busy stays low, so one item per cycle is accepted.
// A tick that writes a pending copy byte holds busy high through the S_READ and
// S_WRITE states while the registered memory read completes; its beat is
// registered from S_WRITE, and no new item is accepted until busy drops.
// Reset (synchronous, active low) clears the parser, counters and checksums;
// the source and target memories are not cleared and are only read where
// written.
module bps_patch_apply_unit #(
    parameter int SOURCE_DEPTH = 65536,
    parameter int TARGET_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_byte_value,
    output logic        o_res_valid,
    output logic        o_out_valid,
    output logic [15:0] o_out_offset,
    output logic [7:0]  o_out_byte,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [2:0]  o_warn_flags,
    output logic        o_size_mismatch
);
    logic [23:0]   r_plen;
    logic [2:0]    r_ign, r_strict;
    bpa_pkg::t_cmd cmd;
    logic          tick_ok;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0; r_ign <= '0; r_strict <= 3'd7;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                bpa_pkg::REG_PLEN:   r_plen   <= pwdata[23:0];
                bpa_pkg::REG_IGNORE: r_ign    <= pwdata[2:0];
                bpa_pkg::REG_STRICT: r_strict <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[3:2])
            bpa_pkg::REG_PLEN:   prdata = {8'd0, r_plen};
            bpa_pkg::REG_IGNORE: prdata = {29'd0, r_ign};
            bpa_pkg::REG_STRICT: prdata = {29'd0, r_strict};
            default:             prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req_type(i_req_type),
        .i_tick_ok(tick_ok), .o_busy(busy), .o_cmd(cmd));

    bpa_datapath #(.SOURCE_DEPTH(SOURCE_DEPTH), .TARGET_DEPTH(TARGET_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte_value(i_byte_value),
        .i_patch_length(r_plen), .i_ignore_crc_mask(r_ign),
        .i_strict_crc_mask(r_strict), .o_tick_ok(tick_ok), .o_res_valid(o_res_valid),
        .o_out_valid(o_out_valid), .o_out_offset(o_out_offset), .o_out_byte(o_out_byte),
        .o_busy_res(o_busy_res), .o_done_res(o_done_res), .o_status(o_status),
        .o_warn_flags(o_warn_flags), .o_size_mismatch(o_size_mismatch));
endmodule

/* rtl/bpa_checker.sv */
// port-level checks for the patch applier
`include "bps_patch_apply_unit_defines.svh"
module bpa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_res_valid,
    input logic       o_out_valid,
    input logic       o_done_res,
    input logic [2:0] o_status
);
    // a written byte is always part of a result beat
    `BPS_ASSERT_ALWAYS(a_out_in_beat, i_clk, i_rst_n, !o_out_valid || o_res_valid)
    // a write never shows alongside an error status
    `BPS_ASSERT_ALWAYS(a_no_write_err, i_clk, i_rst_n,
        !o_out_valid || o_status == bpa_pkg::ST_OK)
    // done stays set
    `BPS_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, o_done_res, o_done_res)
    // an error status sticks
    `BPS_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, o_status != bpa_pkg::ST_OK,
        o_status == $past(o_status))
    // an accepted item gives its beat next cycle or starts a copy read
    `BPS_ASSERT_NEXT(a_accept_resp, i_clk, i_rst_n, start && !busy, o_res_valid || busy)
endmodule

bind bps_patch_apply_unit bpa_checker u_bpa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_res_valid(o_res_valid), .o_out_valid(o_out_valid),
    .o_done_res(o_done_res), .o_status(o_status));

/* sim/bps_patch_apply_unit_checker.sv */
`timescale 1ns / 100ps
// checker for the bps patch applier: watches items and results, predicts and compares
module bps_patch_apply_unit_checker
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_byte_value,
    input  logic        i_res_valid,
    input  logic        i_out_valid,
    input  logic [15:0] i_out_offset,
    input  logic [7:0]  i_out_byte,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic [2:0]  i_status,
    input  logic [2:0]  i_warn_flags,
    input  logic        i_size_mismatch,
    output int          o_fail_count,
    output int          o_pending
);
    localparam logic [1:0] ACT_TCOPY = 2'd3;
    localparam int unsigned SRC_DEPTH = 65536;
    localparam int unsigned TGT_DEPTH = 65536;
    localparam longint unsigned SAT32 = 64'hFFFF_FFFF;
    localparam string MAGIC = "BPS1";

    // one result beat as the block reports it
    typedef struct packed {
        logic        wr_valid;
        logic [15:0] wr_offset;
        logic [7:0]  wr_byte;
        logic        pending;
        logic        done;
        logic [2:0]  status;
        logic [2:0]  warn;
        logic        size_mm;
    } beat_t;

    beat_t expected_beats[$];

    // applier state
    logic [7:0]       src_mem [0:SRC_DEPTH-1];
    logic [7:0]       tgt_mem [0:TGT_DEPTH-1];
    logic [7:0]       footer [0:FOOTER_LEN-1];
    int unsigned      plen;
    logic [2:0]       ignore_mask, strict_mask;
    int unsigned      src_cnt, pat_pos, decl_src, decl_tgt, meta_left;
    int unsigned      run_left, wr_off, src_rel, tgt_rel;
    int unsigned      crc_pat, crc_src, crc_tgt;
    longint unsigned  v_acc, v_shift;
    logic [1:0]       act;
    t_phase           phase;
    logic [2:0]       status_q, warn_q;
    bit               src_known, finished;
    bit               wv;
    int unsigned      w_off;
    logic [7:0]       w_byte;
    int               fails;

    function automatic int unsigned crc_step(input int unsigned crc, input logic [7:0] b);
        int unsigned c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    function automatic void clear_state();
        plen = 0; ignore_mask = 3'd0; strict_mask = 3'd7;
        src_cnt = 0; pat_pos = 0; phase = PH_MAGIC;
        v_acc = 0; v_shift = 1;
        decl_src = 0; decl_tgt = 0; meta_left = 0;
        act = ACT_SREAD; run_left = 0; wr_off = 0; src_rel = 0; tgt_rel = 0;
        crc_pat = '1; crc_src = '1; crc_tgt = '1;
        for (int i = 0; i < FOOTER_LEN; i++) footer[i] = 8'd0;
        status_q = ST_OK; warn_q = 3'd0;
        src_known = 0; finished = 0;
    endfunction

    function automatic void raise_error(input logic [2:0] code);
        status_q = code;
        phase = PH_ERROR;
    endfunction

    function automatic int unsigned footer_word(input int at);
        return {footer[at+3], footer[at+2], footer[at+1], footer[at]};
    endfunction

    // compare running checksums with the footer: patch, source, target
    function automatic void run_checks();
        int unsigned stored [3];
        int unsigned actual [3];
        stored[0] = footer_word(8); stored[1] = footer_word(0); stored[2] = footer_word(4);
        actual[0] = ~crc_pat; actual[1] = ~crc_src; actual[2] = ~crc_tgt;
        finished = 1;
        phase = PH_DONE;
        for (int i = 0; i < 3; i++) begin
            if (ignore_mask[i]) continue;
            if (stored[i] != actual[i]) begin
                if (strict_mask[i]) begin
                    raise_error(ST_PCRC + 3'(i));
                    return;
                end
                warn_q[i] = 1'b1;
            end
        end
    endfunction

    // saturating varint accumulation, true on the final byte
    function automatic bit varint_byte(input logic [7:0] b);
        v_acc += longint'(b[6:0]) * v_shift;
        if (v_acc > SAT32) v_acc = SAT32;
        if (b[7]) return 1;
        v_shift <<= 7;
        if (v_shift > SAT32 + 1) v_shift = SAT32 + 1;
        v_acc += v_shift;
        if (v_acc > SAT32) v_acc = SAT32;
        return 0;
    endfunction

    function automatic int unsigned varint_value();
        int unsigned v;
        v = int'(v_acc);
        v_acc = 0;
        v_shift = 1;
        return v;
    endfunction

    function automatic bit put_target(input logic [7:0] b);
        if (wr_off >= decl_tgt || wr_off >= TGT_DEPTH) begin
            raise_error(ST_RANGE);
            return 0;
        end
        tgt_mem[wr_off] = b;
        crc_tgt = crc_step(crc_tgt, b);
        wv = 1; w_off = wr_off; w_byte = b;
        wr_off++;
        return 1;
    endfunction

    function automatic void run_advance();
        run_left--;
        if (run_left == 0) phase = PH_CMD;
    endfunction

    function automatic void parse(input logic [7:0] b, input int unsigned p);
        int unsigned v;
        case (phase)
            PH_MAGIC: begin
                if (p > 3 || b != MAGIC[p]) begin
                    raise_error(ST_MAGIC);
                    return;
                end
                if (p == 3) phase = PH_SRCSIZE;
            end
            PH_SRCSIZE: if (varint_byte(b)) begin
                decl_src = varint_value();
                src_known = 1;
                phase = PH_TGTSIZE;
            end
            PH_TGTSIZE: if (varint_byte(b)) begin
                decl_tgt = varint_value();
                if (decl_tgt > TGT_DEPTH) begin
                    raise_error(ST_RANGE);
                    return;
                end
                phase = PH_METASIZE;
            end
            PH_METASIZE: if (varint_byte(b)) begin
                meta_left = varint_value();
                phase = (meta_left != 0) ? PH_META : PH_CMD;
            end
            PH_META: begin
                meta_left--;
                if (meta_left == 0) phase = PH_CMD;
            end
            PH_CMD: begin
                // command boundary inside the footer region
                if (p >= plen - FOOTER_LEN) begin
                    phase = PH_FOOTER;
                    return;
                end
                if (varint_byte(b)) begin
                    v = varint_value();
                    act = v[1:0];
                    run_left = (v >> 2) + 1;
                    if (act == ACT_SREAD) phase = PH_COPY;
                    else if (act == ACT_TREAD) phase = PH_TREAD;
                    else phase = PH_OFFSET;
                end
            end
            PH_TREAD: if (put_target(b)) run_advance();
            PH_OFFSET: if (varint_byte(b)) begin
                v = varint_value();
                if (act == ACT_SCOPY)
                    src_rel = v[0] ? src_rel - (v >> 1) : src_rel + (v >> 1);
                else
                    tgt_rel = v[0] ? tgt_rel - (v >> 1) : tgt_rel + (v >> 1);
                phase = PH_COPY;
            end
            default: ;
        endcase
    endfunction

    function automatic void take_patch_byte(input logic [7:0] b);
        int unsigned p;
        p = pat_pos;
        // not consumed while copy bytes are pending
        if (phase == PH_COPY) return;
        if (plen < MIN_PATCH) begin
            raise_error(ST_SMALL);
            return;
        end
        if (p < plen - 4) crc_pat = crc_step(crc_pat, b);
        if (p >= plen - FOOTER_LEN && p < plen) footer[p - (plen - FOOTER_LEN)] = b;
        parse(b, p);
        pat_pos = (p + 1) & 32'h00FF_FFFF;
        if (phase != PH_ERROR && phase != PH_COPY && pat_pos >= plen) run_checks();
    endfunction

    function automatic void take_tick();
        logic [7:0] b;
        if (phase != PH_COPY) return;
        if (act == ACT_SREAD) begin
            if (wr_off >= src_cnt) begin
                raise_error(ST_RANGE);
                return;
            end
            b = src_mem[wr_off];
        end else if (act == ACT_SCOPY) begin
            if (src_rel >= src_cnt) begin
                raise_error(ST_RANGE);
                return;
            end
            b = src_mem[src_rel];
            src_rel++;
        end else begin
            if (tgt_rel >= wr_off || tgt_rel >= TGT_DEPTH) begin
                raise_error(ST_RANGE);
                return;
            end
            b = tgt_mem[tgt_rel];
            tgt_rel++;
        end
        if (!put_target(b)) return;
        run_advance();
        if (phase == PH_CMD && pat_pos >= plen) run_checks();
    endfunction

    // one accepted item -> the beat it must produce
    function automatic beat_t apply_item(input logic [1:0] req, input logic [7:0] b);
        beat_t r;
        wv = 0; w_off = 0; w_byte = 8'd0;
        if (phase != PH_ERROR && phase != PH_DONE) begin
            if (req == REQ_SRC) begin
                if (pat_pos == 0 && src_cnt < SRC_DEPTH) begin
                    src_mem[src_cnt] = b;
                    src_cnt++;
                    crc_src = crc_step(crc_src, b);
                end
            end else if (req == REQ_PAT) begin
                take_patch_byte(b);
            end else if (req == REQ_TICK) begin
                take_tick();
            end
        end
        if (phase == PH_ERROR) wv = 0;
        r.wr_valid  = wv;
        r.wr_offset = wv ? w_off[15:0] : 16'd0;
        r.wr_byte   = wv ? w_byte : 8'd0;
        r.pending   = (phase == PH_COPY);
        r.done      = finished;
        r.status    = status_q;
        r.warn      = warn_q;
        r.size_mm   = src_known && (src_cnt != decl_src);
        return r;
    endfunction

    initial begin
        clear_state();
        fails = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    // register writes, result compare, then item prediction
    always @(posedge i_clk) begin
        beat_t got, exp_b;
        if (!i_rst_n) begin
            clear_state();
            expected_beats.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_PLEN:   plen = {8'd0, i_pwdata[23:0]};
                    REG_IGNORE: ignore_mask = i_pwdata[2:0];
                    REG_STRICT: strict_mask = i_pwdata[2:0];
                    default: ;
                endcase
            end
            if (i_res_valid) begin
                got = '{i_out_valid, i_out_offset, i_out_byte, i_busy_res, i_done_res,
                        i_status, i_warn_flags, i_size_mismatch};
                if (expected_beats.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("ERROR %0t: result beat with none expected", $time);
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (got !== exp_b) begin
                        fails++;
                        if (fails <= 10)
                            $display({"ERROR %0t: wr %0d/%0d off %h/%h byte %h/%h busy %0d/%0d",
                                      " done %0d/%0d st %0d/%0d warn %0d/%0d smm %0d/%0d",
                                      " (exp/act)"}, $time,
                                     exp_b.wr_valid, got.wr_valid, exp_b.wr_offset,
                                     got.wr_offset, exp_b.wr_byte, got.wr_byte,
                                     exp_b.pending, got.pending, exp_b.done, got.done,
                                     exp_b.status, got.status, exp_b.warn, got.warn,
                                     exp_b.size_mm, got.size_mm);
                    end
                end
            end
            if (i_start && !i_busy) expected_beats.push_back(apply_item(i_req_type, i_byte_value));
        end
        o_fail_count <= fails;
        o_pending <= expected_beats.size();
    end
endmodule

/* sim/bps_patch_apply_unit_tb.sv */
`timescale 1ns / 100ps
// testbench top for the bps patch applier: builds a patch stream, drives it, gives the verdict
module bps_patch_apply_unit_tb;
    import bpa_pkg::*;

    localparam logic [1:0] REQ_NONE  = 2'd3;
    localparam logic [1:0] ACT_TCOPY = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    // scenario codes
    localparam int SC_CLEAN    = 0;
    localparam int SC_SMALL    = 1;
    localparam int SC_MAGIC    = 2;
    localparam int SC_SHORTTGT = 3;
    localparam int SC_HUGETGT  = 4;
    localparam int SC_SATURATE = 5;
    localparam int SC_TRUNC    = 6;

    typedef struct {
        logic [1:0] req;
        logic [7:0] val;
        bit         hold;
    } item_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = REQ_SRC;
    logic [7:0]  i_byte_value = 8'd0;
    logic        o_res_valid, o_out_valid, o_busy_res, o_done_res, o_size_mismatch;
    logic [15:0] o_out_offset;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_status, o_warn_flags;
    int          fail_count, pending;
    int          cycles = 0;

    item_t       items[$];
    logic [7:0]  src_img[$], tgt_img[$], patch_img[$];
    int          scenario;
    int unsigned patch_len;

    bps_patch_apply_unit i_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .start, .busy, .i_req_type, .i_byte_value, .o_res_valid, .o_out_valid,
        .o_out_offset, .o_out_byte, .o_busy_res, .o_done_res, .o_status, .o_warn_flags,
        .o_size_mismatch
    );

    bps_patch_apply_unit_checker i_checker (
        .i_clk, .i_rst_n, .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready), .i_start(start),
        .i_busy(busy), .i_req_type, .i_byte_value, .i_res_valid(o_res_valid),
        .i_out_valid(o_out_valid), .i_out_offset(o_out_offset), .i_out_byte(o_out_byte),
        .i_busy_res(o_busy_res), .i_done_res(o_done_res), .i_status(o_status),
        .i_warn_flags(o_warn_flags), .i_size_mismatch(o_size_mismatch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned crc_of(input int first, input int last);
        int unsigned c;
        c = '1;
        for (int k = first; k <= last; k++) begin
            c ^= {24'd0, patch_img[k]};
            for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return ~c;
    endfunction

    function automatic void add_item(input logic [1:0] req, input logic [7:0] val);
        items.push_back('{req, val, 1'b0});
    endfunction

    function automatic void add_patch(input logic [7:0] b);
        patch_img.push_back(b);
        add_item(REQ_PAT, b);
    endfunction

    function automatic void add_varint(input int unsigned v);
        logic [7:0] x;
        forever begin
            x = {1'b0, v[6:0]};
            v >>= 7;
            if (v == 0) begin
                add_patch(x | 8'h80);
                return;
            end
            add_patch(x);
            v--;
        end
    endfunction

    // relative offset field: bit0 sign, rest magnitude
    function automatic void add_rel(input int unsigned to, inout int unsigned cur);
        int d;
        d = int'(to) - int'(cur);
        add_varint(d < 0 ? ((-d) << 1) | 1 : d << 1);
        cur = to;
    endfunction

    // build the whole item stream for one patch session
    task automatic build_stream();
        int unsigned src_n, tgt_n, meta_n, wo, len, a, s_rel, t_rel, crc_w;
        logic [1:0]  op;
        logic [7:0]  ftr [12];
        int          first_pat, mid;
        scenario = $urandom_range(0, 9);
        if (scenario > SC_TRUNC) scenario = SC_CLEAN;
        // idle tick, no-op request, then source bytes with extremes first
        add_item(REQ_TICK, 8'hFF);
        add_item(REQ_NONE, 8'h00);
        src_n = $urandom_range(64, 160);
        for (int i = 0; i < src_n; i++) begin
            src_img.push_back(i == 0 ? 8'h00 : i == 1 ? 8'hFF : 8'($urandom));
            add_item(REQ_SRC, src_img[i]);
        end
        add_item(REQ_NONE, 8'hFF);
        first_pat = items.size();
        // header
        add_patch("B"); add_patch("P"); add_patch("S");
        add_item(REQ_SRC, 8'($urandom));   // late source byte, ignored
        add_patch(scenario == SC_MAGIC ? 8'($urandom_range(0, 48)) : "1");
        if (scenario == SC_SATURATE) begin
            repeat (5) add_patch(8'h7F);
            add_patch(8'h80);
        end else begin
            add_varint(src_n);
        end
        tgt_n = $urandom_range(750, 1000);
        if (scenario == SC_SHORTTGT) add_varint(tgt_n - $urandom_range(1, 20));
        else if (scenario == SC_HUGETGT) add_varint(65537 + $urandom_range(0, 5000));
        else add_varint(tgt_n);
        meta_n = $urandom_range(0, 3);
        add_varint(meta_n);
        repeat (meta_n) add_patch(8'($urandom));
        // commands until the target is complete
        wo = 0; s_rel = 0; t_rel = 0;
        while (wo < tgt_n) begin
            op = 2'($urandom_range(0, 3));
            len = $urandom_range(1, 16);
            if (len > tgt_n - wo) len = tgt_n - wo;
            if (op == ACT_SREAD && wo + len > src_n) op = ACT_TREAD;
            if (op == ACT_TCOPY && wo == 0) op = ACT_TREAD;
            add_varint(((len - 1) << 2) | op);
            case (op)
                ACT_TREAD: repeat (len) begin
                    tgt_img.push_back(8'($urandom));
                    add_patch(tgt_img[$]);
                end
                ACT_SREAD: for (int k = 0; k < len; k++) tgt_img.push_back(src_img[wo + k]);
                ACT_SCOPY: begin
                    a = $urandom_range(0, src_n - len);
                    add_rel(a, s_rel);
                    for (int k = 0; k < len; k++) tgt_img.push_back(src_img[a + k]);
                    s_rel = a + len;
                end
                default: begin
                    a = $urandom_range(0, wo - 1);
                    add_rel(a, t_rel);
                    // may overlap the bytes being written
                    for (int k = 0; k < len; k++) tgt_img.push_back(tgt_img[a + k]);
                    t_rel = a + len;
                end
            endcase
            if (op != ACT_TREAD) begin
                // a patch byte while copy bytes are pending is ignored
                if ($urandom_range(0, 4) == 0) add_item(REQ_PAT, 8'($urandom));
                repeat (len) add_item(REQ_TICK, 8'($urandom));
            end
            wo += len;
        end
        // footer: source, target, patch checksums
        crc_w = 0;
        for (int k = 0; k < src_n; k++) begin
            crc_w = crc_w ^ 0;
        end
        begin
            int unsigned c;
            c = '1;
            foreach (src_img[k]) begin
                c ^= {24'd0, src_img[k]};
                for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
            end
            {ftr[3], ftr[2], ftr[1], ftr[0]} = ~c;
            c = '1;
            foreach (tgt_img[k]) begin
                c ^= {24'd0, tgt_img[k]};
                for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
            end
            {ftr[7], ftr[6], ftr[5], ftr[4]} = ~c;
        end
        for (int k = 0; k < 8; k++) patch_img.push_back(ftr[k]);
        {ftr[11], ftr[10], ftr[9], ftr[8]} = crc_of(0, patch_img.size() - 1);
        for (int k = 0; k < 8; k++) void'(patch_img.pop_back());
        // corrupt one checksum byte now and then
        if ($urandom_range(0, 2) == 0) ftr[$urandom_range(0, 11)] ^= 8'($urandom_range(1, 255));
        for (int k = 0; k < 12; k++) add_patch(ftr[k]);
        patch_len = patch_img.size();
        if (scenario == SC_TRUNC) patch_len -= $urandom_range(1, 20);
        if (scenario == SC_SMALL) patch_len = $urandom_range(0, MIN_PATCH - 1);
        // items after the end have no effect
        add_item(REQ_TICK, 8'h00);
        add_item(REQ_PAT, 8'h55);
        add_item(REQ_SRC, 8'hAA);
        items[first_pat].hold = 1'b1;
        mid = $urandom_range(first_pat + 40, items.size() - 20);
        items[mid].hold = 1'b1;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [2:0] pick_mask();
        int r;
        r = $urandom_range(0, 3);
        return r == 0 ? 3'd0 : r == 1 ? 3'd7 : 3'($urandom);
    endfunction

    // wait for every expected beat, then let the block settle
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int burst;
        build_stream();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes first, overwritten before the patch starts
        reg_write(REG_PLEN, 32'h00FF_FFFF);
        reg_write(REG_IGNORE, 32'd7);
        reg_write(REG_STRICT, 32'd0);
        reg_write(REG_PLEN, 32'd0);
        @(posedge i_clk);
        burst = $urandom_range(1, 30);
        foreach (items[n]) begin
            if (items[n].hold) begin
                drain();
                if (n == 0 || items[n - 1].req != REQ_PAT) reg_write(REG_PLEN, patch_len);
                reg_write(REG_IGNORE, pick_mask());
                reg_write(REG_STRICT, pick_mask());
                @(posedge i_clk);
            end
            // burst of back-to-back beats, then a random gap
            if (burst == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
            end
            burst--;
            start <= 1'b1;
            i_req_type <= items[n].req;
            i_byte_value <= items[n].val;
            do @(posedge i_clk); while (busy);
        end
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
